// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the conditioner RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define LCWC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lcwc assertion failed");

// check that a condition is followed by another in the next cycle
`define LCWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcwc assertion failed");

`endif

// File: hw/rtl/lcwc_pkg.sv
// ----------------------------------------------------------------------------
// Load cell conditioner package
// Types, register indexes, the smoothing table and saturation helper.
// ----------------------------------------------------------------------------
package lcwc_pkg;

  localparam int WeightFracBitsDef = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CfgZeroRaw    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTwentyRaw  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgFiftyRaw   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHundredRaw = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPiecewise  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDivisor    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgTareRaw    = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSmoothing  = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEL,
    ST_SETUP,
    ST_LOAD,
    ST_DIVIDE,
    ST_FINISH,
    ST_NET,
    ST_MULT,
    ST_EMA,
    ST_CMP,
    ST_EMIT
  } state_e;

  function automatic logic [16:0] alpha_q16(input logic [7:0] code);
    case (code)
      8'd2:    alpha_q16 = 17'd32768;
      8'd4:    alpha_q16 = 17'd16384;
      8'd6:    alpha_q16 = 17'd10945;
      8'd8:    alpha_q16 = 17'd8192;
      8'd16:   alpha_q16 = 17'd4096;
      8'd32:   alpha_q16 = 17'd2032;
      8'd64:   alpha_q16 = 17'd983;
      8'd128:  alpha_q16 = 17'd511;
      default: alpha_q16 = 17'd4096;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// File: hw/rtl/load_cell_weight_conditioner.sv
// Flow: each sample runs the bit-serial divider for the sample and then for the tare; the first
//   sample after reset or a register write skips the smoothing steps and is always emitted.
// Samples: a new one is taken only in idle, after the last is finished; a stalled result blocks
//   the next one.
// Reset: registers take their calibration defaults, filter restarts.
// ----------------------------------------------------------------------------
// Load cell weight conditioner
// Calibrated conversion to grams, tare, EMA smoothing and change gating.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module load_cell_weight_conditioner #(
  parameter int WEIGHT_FRAC_BITS = lcwc_pkg::WeightFracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [23:0]            raw_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            shown_weight_o,
  input  logic                          cfg_we_i,
  input  logic [lcwc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lcwc_pkg::CfgDataW-1:0] cfg_data_i
);
  import lcwc_pkg::*;

  localparam int F = WEIGHT_FRAC_BITS;
  localparam int DW = 32 + F;
  localparam int RW = DW + 2;
  localparam logic [32:0] Thresh = 33'(((1 << F) + 5) / 10);

  state_e state_q, state_d;

  logic signed [23:0] c0_q, c20_q, c50_q, c100_q, tare_q, raw_q;
  logic               pw_q;
  logic [23:0]        lin_q;
  logic [7:0]         smset_q;
  logic               first_q, pass_q;

  logic signed [23:0] x;
  logic signed [25:0] d0, v, t20, t50;
  logic               pol;
  logic signed [24:0] diff_q;
  logic signed [25:0] den_q;
  logic [5:0]         base_q, span_q;
  logic signed [32:0] pnum;
  logic [31:0]        pmag_q;
  logic [24:0]        ud_q;
  logic               neg_q, zero_q;
  logic               div_start;
  logic [DW-1:0]      dividend, quot;
  logic               div_done;
  logic signed [RW-1:0] qw, sres;
  logic signed [31:0] gs_q, gt_q, smooth_q, last_q, out_q;
  logic signed [32:0] delta_q, gap_full;
  logic signed [49:0] prod_q;
  logic [49:0]        pmag50;
  logic [33:0]        rstep;
  logic signed [34:0] step, ssum;
  logic [32:0]        gap;
  logic               out_valid_q;

  lcwc_div #(.DIV_W(DW), .DEN_W(25)) u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (ud_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    x   = pass_q ? tare_q : raw_q;
    pol = c20_q > c0_q;
    d0  = 26'(x) - 26'(c0_q);
    v   = pol ? d0 : -d0;
    t20 = pol ? 26'(c20_q) - 26'(c0_q) : 26'(c0_q) - 26'(c20_q);
    t50 = pol ? 26'(c50_q) - 26'(c0_q) : 26'(c0_q) - 26'(c50_q);
    pnum = $signed({{8{diff_q[24]}}, diff_q}) * $signed({27'b0, span_q});
    dividend = (DW'(pmag_q) << F) + DW'(ud_q >> 1);
    qw   = zero_q ? '0 : $signed({2'b00, quot});
    sres = $signed(RW'(base_q) << F) + (neg_q ? -qw : qw);
    pmag50 = prod_q[49] ? 50'(-prod_q) : 50'(prod_q);
    rstep  = 34'((pmag50 + 50'd32768) >> 16);
    step   = prod_q[49] ? -$signed({1'b0, rstep}) : $signed({1'b0, rstep});
    ssum   = 35'(smooth_q) + step;
    gap_full = 33'(smooth_q) - 33'(last_q);
    gap      = gap_full[32] ? 33'(-gap_full) : 33'(gap_full);
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SEL;
      ST_SEL:    state_d = ST_SETUP;
      ST_SETUP:  state_d = ST_LOAD;
      ST_LOAD: begin
        div_start = 1'b1;
        state_d   = ST_DIVIDE;
      end
      ST_DIVIDE: if (div_done) state_d = ST_FINISH;
      ST_FINISH: state_d = pass_q ? ST_NET : ST_SEL;
      ST_NET:    state_d = first_q ? ST_EMIT : ST_MULT;
      ST_MULT:   state_d = ST_EMA;
      ST_EMA:    state_d = ST_CMP;
      ST_CMP:    state_d = (gap >= Thresh) ? ST_EMIT : ST_IDLE;
      ST_EMIT:   if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = state_q != ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      c0_q        <= '0;
      c20_q       <= 24'sd200000;
      c50_q       <= 24'sd500000;
      c100_q      <= 24'sd1000000;
      pw_q        <= 1'b0;
      lin_q       <= 24'd10000;
      tare_q      <= '0;
      smset_q     <= 8'd2;
      first_q     <= 1'b1;
      pass_q      <= 1'b0;
      smooth_q    <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        first_q <= 1'b1;
        case (cfg_idx_i)
          CfgZeroRaw:    c0_q    <= $signed(cfg_data_i);
          CfgTwentyRaw:  c20_q   <= $signed(cfg_data_i);
          CfgFiftyRaw:   c50_q   <= $signed(cfg_data_i);
          CfgHundredRaw: c100_q  <= $signed(cfg_data_i);
          CfgPiecewise:  pw_q    <= cfg_data_i[0];
          CfgDivisor:    lin_q   <= cfg_data_i;
          CfgTareRaw:    tare_q  <= $signed(cfg_data_i);
          CfgSmoothing:  smset_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (state_q == ST_IDLE) pass_q <= 1'b0;
      if (state_q == ST_FINISH) pass_q <= 1'b1;
      if (state_q == ST_NET && first_q) begin
        smooth_q <= sat32(64'(gs_q) - 64'(gt_q));
        first_q  <= 1'b0;
      end
      if (state_q == ST_EMA) smooth_q <= sat32(64'(ssum));
      if (state_q == ST_EMIT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
        last_q      <= smooth_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) raw_q <= raw_sample_i;
    if (state_q == ST_SEL) begin
      if (!pw_q) begin
        diff_q <= 25'(x);
        den_q  <= $signed({2'b00, lin_q});
        base_q <= 6'd0;
        span_q <= 6'd1;
      end else if (v <= t20) begin
        diff_q <= 25'(x) - 25'(c0_q);
        den_q  <= 26'(c20_q) - 26'(c0_q);
        base_q <= 6'd0;
        span_q <= 6'd20;
      end else if (v <= t50) begin
        diff_q <= 25'(x) - 25'(c20_q);
        den_q  <= 26'(c50_q) - 26'(c20_q);
        base_q <= 6'd20;
        span_q <= 6'd30;
      end else begin
        diff_q <= 25'(x) - 25'(c50_q);
        den_q  <= 26'(c100_q) - 26'(c50_q);
        base_q <= 6'd50;
        span_q <= 6'd50;
      end
    end
    if (state_q == ST_SETUP) begin
      pmag_q <= pnum[32] ? 32'(-pnum) : 32'(pnum);
      neg_q  <= pnum[32] ^ den_q[25];
      ud_q   <= den_q[25] ? 25'(-den_q) : 25'(den_q);
      zero_q <= pnum == '0;
    end
    if (state_q == ST_FINISH) begin
      if (pass_q) gt_q <= sat32(64'(sres));
      else        gs_q <= sat32(64'(sres));
    end
    if (state_q == ST_NET) delta_q <= 33'(sat32(64'(gs_q) - 64'(gt_q))) - 33'(smooth_q);
    if (state_q == ST_MULT) prod_q <= 50'(delta_q) * $signed({33'b0, alpha_q16(smset_q)});
    if (state_q == ST_EMIT && (!out_valid_q || !out_stall_i)) out_q <= smooth_q;
  end

  assign out_valid_o    = out_valid_q;
  assign shown_weight_o = out_q;

  `LCWC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `LCWC_ASSERT_NEXT(a_cfg_restart, clk_i, rst_ni, cfg_we_i, first_q)
  `LCWC_ASSERT(a_out_last, clk_i, rst_ni, !out_valid_o || out_q == last_q)
endmodule

// File: hw/rtl/lcwc_div.sv
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcwc_div #(
  parameter int DIV_W = 48,
  parameter int DEN_W = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);
  localparam int CntW = $clog2(DIV_W + 1);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DIV_W-1:0] quot_q, quot_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic             bit_set;

  always_comb begin
    trial   = {rem_q, quot_q[DIV_W-1]};
    bit_set = trial >= {1'b0, den_q};
    rem_d   = rem_q;
    den_d   = den_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      den_d  = divisor_i;
      quot_d = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = bit_set ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quot_d = {quot_q[DIV_W-2:0], bit_set};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntW'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load cell conditioner testbench
// Drives signed samples through the conditioner under random input gaps and
// output stalls, predicts each emitted weight in fixed point and compares it
// against the output stream. A short table of directed rows opens the run,
// followed by random phases with fresh calibration settings.
// ----------------------------------------------------------------------------
module tb_top;
  import lcwc_pkg::*;

  localparam int FRAC = WeightFracBitsDef;
  localparam int SETTLE = 2 * (FRAC + 37) + 200;
  localparam int WDOG_LIMIT = 5000;
  localparam longint BIG = longint'(1) << 40;

  typedef struct {
    bit                 do_cfg;
    logic [CfgIdxW-1:0] idx;
    logic [23:0]        data;
    logic signed [23:0] raw;
    bit                 typed;
    logic signed [31:0] want;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [23:0]   raw_sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [31:0]   shown_weight;
  logic                 cfg_we = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  // predictor state
  longint             cal_pt [4];
  bit                 pw_en;
  longint             div_cnt;
  longint             tare_cnt;
  logic [7:0]         smooth_code;
  logic signed [31:0] ema_w;
  logic signed [31:0] last_w;
  bit                 restart;

  logic signed [31:0] weight_q [$];
  row_t               rows [$];
  int                 errors = 0;
  int                 idle_cycles = 0;
  int                 burst_left = 0;

  load_cell_weight_conditioner u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .raw_sample_i  (raw_sample),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .shown_weight_o(shown_weight),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint round_div(longint n, longint d);
    longint un, ud, q;
    if (d == 0) return (n > 0) ? BIG : ((n < 0) ? -BIG : 0);
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = (un + ud / 2) / ud;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint seg_value(longint r, longint s, longint e, longint base,
                                       longint span);
    return base * (longint'(1) << FRAC) + round_div((r - s) * span * (longint'(1) << FRAC), e - s);
  endfunction

  function automatic logic signed [31:0] grams(longint r);
    longint pol;
    if (!pw_en) return clamp32(round_div(r * (longint'(1) << FRAC), div_cnt));
    pol = (cal_pt[1] > cal_pt[0]) ? 1 : -1;
    if ((r - cal_pt[0]) * pol <= (cal_pt[1] - cal_pt[0]) * pol)
      return clamp32(seg_value(r, cal_pt[0], cal_pt[1], 0, 20));
    if ((r - cal_pt[0]) * pol <= (cal_pt[2] - cal_pt[0]) * pol)
      return clamp32(seg_value(r, cal_pt[1], cal_pt[2], 20, 30));
    return clamp32(seg_value(r, cal_pt[2], cal_pt[3], 50, 50));
  endfunction

  function automatic longint alpha_of(logic [7:0] code);
    case (code)
      8'd2:    return 32768;
      8'd4:    return 16384;
      8'd6:    return 10945;
      8'd8:    return 8192;
      8'd16:   return 4096;
      8'd32:   return 2032;
      8'd64:   return 983;
      8'd128:  return 511;
      default: return 4096;
    endcase
  endfunction

  function automatic void apply_cfg(logic [CfgIdxW-1:0] idx, logic [23:0] d);
    case (idx)
      CfgZeroRaw:    cal_pt[0] = longint'(signed'(d));
      CfgTwentyRaw:  cal_pt[1] = longint'(signed'(d));
      CfgFiftyRaw:   cal_pt[2] = longint'(signed'(d));
      CfgHundredRaw: cal_pt[3] = longint'(signed'(d));
      CfgPiecewise:  pw_en = d[0];
      CfgDivisor:    div_cnt = longint'(d);
      CfgTareRaw:    tare_cnt = longint'(signed'(d));
      CfgSmoothing:  smooth_code = d[7:0];
      default: ;
    endcase
    restart = 1'b1;
  endfunction

  // returns 1 when the sample produces an output weight
  function automatic bit predict_weight(logic signed [23:0] r, output logic signed [31:0] w);
    logic signed [31:0] net;
    longint gap;
    net = clamp32(longint'(grams(longint'(r))) - longint'(grams(tare_cnt)));
    if (restart) begin
      ema_w = net;
      restart = 1'b0;
    end else begin
      ema_w = clamp32(longint'(ema_w) +
                      round_div((longint'(net) - longint'(ema_w)) * alpha_of(smooth_code),
                                65536));
      gap = longint'(ema_w) - longint'(last_w);
      if (gap < 0) gap = -gap;
      if (gap < ((longint'(1) << FRAC) + 5) / 10) return 1'b0;
    end
    last_w = ema_w;
    w = ema_w;
    return 1'b1;
  endfunction

  task automatic drain();
    while (weight_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [23:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    apply_cfg(idx, d);
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic signed [23:0] r, bit typed, logic signed [31:0] want);
    logic signed [31:0] w;
    in_valid   <= 1'b1;
    raw_sample <= r;
    do @(posedge clk_i); while (in_stall);
    if (predict_weight(r, w)) weight_q.push_back(typed ? want : w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic add_row(bit c, logic [CfgIdxW-1:0] i, logic [23:0] d, logic signed [23:0] r,
                         bit t, logic signed [31:0] w);
    row_t x;
    x.do_cfg = c; x.idx = i; x.data = d; x.raw = r; x.typed = t; x.want = w;
    rows.push_back(x);
  endtask

  // receiver: stall on a pattern that changes character over time
  int stall_pct = 0;
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(10, 300);
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 30;
        default: stall_pct = 80;
      endcase
    end else begin
      stall_left--;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (weight_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected weight %0d", shown_weight);
      end else begin
        if (shown_weight !== weight_q[0]) begin
          errors++;
          if (errors <= 10)
            $display("weight mismatch: expected %0d actual %0d", weight_q[0], shown_weight);
        end
        void'(weight_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic signed [23:0] held, r;
    int z, s1, s2, s3, pol;
    cal_pt[0] = 0; cal_pt[1] = 200000; cal_pt[2] = 500000; cal_pt[3] = 1000000;
    pw_en = 1'b0; div_cnt = 10000; tare_cnt = 0; smooth_code = 8'd2;
    ema_w = '0; last_w = '0; restart = 1'b1;

    add_row(0, CfgZeroRaw, 0, 24'sd0, 1, 32'sd0);
    add_row(0, CfgZeroRaw, 0, 24'sd10000, 0, 0);
    add_row(0, CfgZeroRaw, 0, 24'sd8388607, 0, 0);
    add_row(0, CfgZeroRaw, 0, -24'sd8388608, 0, 0);
    add_row(1, CfgDivisor, 24'd1, 24'sd8388607, 1, 32'sh7fffffff);
    add_row(0, CfgZeroRaw, 0, -24'sd8388608, 0, 0);
    add_row(1, CfgDivisor, 24'd0, 24'sd5, 1, 32'sh7fffffff);
    add_row(0, CfgZeroRaw, 0, -24'sd5, 0, 0);
    add_row(0, CfgZeroRaw, 0, 24'sd0, 0, 0);
    add_row(1, CfgDivisor, 24'hffffff, 24'sd8388607, 0, 0);
    add_row(1, CfgPiecewise, 24'd1, 24'sd0, 1, 32'sd0);
    add_row(0, CfgZeroRaw, 0, 24'sd200000, 0, 0);
    add_row(0, CfgZeroRaw, 0, 24'sd350000, 0, 0);
    add_row(0, CfgZeroRaw, 0, 24'sd1500000, 0, 0);
    add_row(0, CfgZeroRaw, 0, -24'sd100000, 0, 0);
    add_row(1, CfgTareRaw, 24'd200000, 24'sd500000, 1, 32'sd1966080);
    add_row(1, CfgTwentyRaw, -24'sd200000, -24'sd200000, 0, 0);
    add_row(1, CfgFiftyRaw, -24'sd200000, -24'sd300000, 0, 0);
    add_row(1, CfgHundredRaw, -24'sd200000, -24'sd500000, 0, 0);
    add_row(1, CfgZeroRaw, -24'sd8388608, 24'sd8388607, 0, 0);
    add_row(1, CfgSmoothing, 24'd128, 24'sd0, 0, 0);
    add_row(0, CfgZeroRaw, 0, 24'sd1000000, 0, 0);
    add_row(1, CfgSmoothing, 24'd6, 24'sd0, 0, 0);
    add_row(0, CfgZeroRaw, 0, 24'sd300000, 0, 0);
    add_row(1, CfgSmoothing, 24'd200, 24'sd0, 0, 0);
    add_row(0, CfgZeroRaw, 0, 24'sd2000000, 0, 0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].do_cfg) begin
        in_valid <= 1'b0;
        drain();
        write_reg(rows[i].idx, rows[i].data);
      end
      send_sample(rows[i].raw, rows[i].typed, rows[i].want);
    end

    for (int ph = 0; ph < 12; ph++) begin
      in_valid <= 1'b0;
      drain();
      pol = $urandom_range(0, 1) ? 1 : -1;
      z  = $urandom_range(0, 1000000) - 500000;
      s1 = z + pol * $urandom_range(100000, 400000);
      s2 = s1 + pol * $urandom_range(100000, 400000);
      s3 = s2 + pol * $urandom_range(100000, 400000);
      if ($urandom_range(0, 5) == 0) s2 = s1;
      if (ph == 5) begin
        z = -8388608; s1 = 8388607; s2 = $urandom; s3 = $urandom;
      end
      if (ph == 0 || $urandom_range(0, 1)) write_reg(CfgZeroRaw, z[23:0]);
      if (ph == 0 || $urandom_range(0, 1)) write_reg(CfgTwentyRaw, s1[23:0]);
      if (ph == 0 || $urandom_range(0, 1)) write_reg(CfgFiftyRaw, s2[23:0]);
      if (ph == 0 || $urandom_range(0, 1)) write_reg(CfgHundredRaw, s3[23:0]);
      write_reg(CfgPiecewise, {23'($urandom), ph[0]});
      case ($urandom_range(0, 3))
        0: write_reg(CfgDivisor, 24'd1);
        1: write_reg(CfgDivisor, 24'hffffff);
        default: write_reg(CfgDivisor, 24'($urandom_range(100, 20000)));
      endcase
      if (ph == 0 || $urandom_range(0, 1))
        write_reg(CfgTareRaw, $urandom_range(0, 3) == 0 ? 24'($urandom) :
                              24'($urandom_range(0, 200000) + z));
      case ($urandom_range(0, 2))
        0: write_reg(CfgSmoothing, 24'($urandom_range(0, 255)));
        default: write_reg(CfgSmoothing, 24'(2 << $urandom_range(0, 6)));
      endcase
      held = 24'($urandom_range(0, 3000000) - 1500000);
      for (int n = 0; n < 52; n++) begin
        if ($urandom_range(0, 9) == 0) held = 24'($urandom_range(0, 3000000) - 1500000);
        if ($urandom_range(0, 6) == 0) r = 24'($urandom);
        else r = held + 24'($urandom_range(0, 4000)) - 24'sd2000;
        if (n == 26 && ph[1]) begin
          in_valid <= 1'b0;
          @(posedge clk_i);
          while (weight_q.size() != 0) @(posedge clk_i);
        end
        send_sample(r, 1'b0, 32'sd0);
      end
    end

    in_valid <= 1'b0;
    while (weight_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: load_cell_weight_conditioner.f
+incdir+hw/rtl
hw/rtl/lcwc_pkg.sv
hw/rtl/lcwc_div.sv
hw/rtl/load_cell_weight_conditioner.sv
bench/tb_top.sv
